// ===== src/ctl_pkg.sv =====
package ctl_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned KindW  = 4;
	localparam int unsigned ErrW   = 3;
	localparam int unsigned LineW  = 16;
	localparam int unsigned CountW = 9;
	localparam int unsigned DataW  = 32;
	localparam int unsigned UserW  = 5;

	// token kinds
	localparam logic [KindW-1:0] KIND_IDENT    = 4'd0;
	localparam logic [KindW-1:0] KIND_STRING   = 4'd1;
	localparam logic [KindW-1:0] KIND_CAST     = 4'd2;
	localparam logic [KindW-1:0] KIND_ASSIGN   = 4'd3;
	localparam logic [KindW-1:0] KIND_SEMI     = 4'd4;
	localparam logic [KindW-1:0] KIND_LBRACE   = 4'd5;
	localparam logic [KindW-1:0] KIND_RBRACE   = 4'd6;
	localparam logic [KindW-1:0] KIND_LBRACKET = 4'd7;
	localparam logic [KindW-1:0] KIND_RBRACKET = 4'd8;
	localparam logic [KindW-1:0] KIND_COMMA    = 4'd9;
	localparam logic [KindW-1:0] KIND_EOF      = 4'd10;
	localparam logic [KindW-1:0] KIND_ERROR    = 4'd11;

	// error codes
	localparam logic [ErrW-1:0] ERR_NONE     = 3'd0;
	localparam logic [ErrW-1:0] ERR_NONPRINT = 3'd1;
	localparam logic [ErrW-1:0] ERR_UNEXP    = 3'd2;
	localparam logic [ErrW-1:0] ERR_EOF_OPEN = 3'd3;
	localparam logic [ErrW-1:0] ERR_TOO_LONG = 3'd4;

	// characters
	localparam logic [CharW-1:0] CH_NL     = 8'h0A;
	localparam logic [CharW-1:0] CH_TAB    = 8'h09;
	localparam logic [CharW-1:0] CH_CR     = 8'h0D;
	localparam logic [CharW-1:0] CH_SPACE  = 8'h20;
	localparam logic [CharW-1:0] CH_TILDE  = 8'h7E;
	localparam logic [CharW-1:0] CH_HASH   = 8'h23;
	localparam logic [CharW-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CharW-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CharW-1:0] CH_LPAREN = 8'h28;
	localparam logic [CharW-1:0] CH_RPAREN = 8'h29;
	localparam logic [CharW-1:0] CH_SEMI   = 8'h3B;
	localparam logic [CharW-1:0] CH_EQ     = 8'h3D;
	localparam logic [CharW-1:0] CH_LBRACK = 8'h5B;
	localparam logic [CharW-1:0] CH_RBRACK = 8'h5D;
	localparam logic [CharW-1:0] CH_LBRACE = 8'h7B;
	localparam logic [CharW-1:0] CH_RBRACE = 8'h7D;
	localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CharW-1:0] CH_USCORE = 8'h5F;
	localparam logic [CharW-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CharW-1:0] CH_DOT    = 8'h2E;

	localparam logic [CountW-1:0] LIMIT_MIN   = 9'd4;
	localparam logic [CountW-1:0] LIMIT_RESET = 9'd256;
	localparam logic [LineW-1:0]  LINE_MAX    = 16'hFFFF;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_IDENT  = 5'b00010,
		MODE_STRING = 5'b00100,
		MODE_CAST   = 5'b01000,
		MODE_ERR    = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [LineW-1:0] line_number;
		logic [ErrW-1:0]  error_code;
		logic             token_end;
		logic             char_valid;
		logic [CharW-1:0] text_char;
		logic [KindW-1:0] token_kind;
	} result_t;

	function automatic logic is_ident_char(input logic [CharW-1:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
			(c >= "A" && c <= "Z") || c == CH_USCORE || c == CH_MINUS || c == CH_DOT;
	endfunction

endpackage

// ===== src/config_text_lexer.sv =====
// Streaming lexer for configuration text. Each input transaction carries one byte
// (s_tdata) or, with s_tuser set, an end-of-input mark. Output transactions are
// tokens streamed one text character at a time: punctuation is a single
// transaction with tlast set; identifiers, strings and casts send their
// characters with tlast clear and close with a marker (char_valid 0, tlast 1).
// '#' starts a comment up to the newline, also inside strings. Any error ends in
// an error transaction, after which the lexer stays silent until reset.
// Throughput: one byte per clock while the output drains. A byte yields zero, one or two
// output transactions; the two-result case (identifier closed by punctuation, a bad
// byte or end of input) occupies the two-entry output buffer, so the input stalls until
// an entry is taken. The byte path is one level of classify-and-update logic between
// the lexer state registers and the output buffer.
module config_text_lexer
	import ctl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CountW-1:0] cfg_wdata,  // token_limit
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [CharW-1:0]  s_tdata,    // [7:0] in_byte
	input  logic              s_tuser,    // end_of_input
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DataW-1:0]  m_tdata,    // [7:0] text_char, [10:8] error_code,
	                                      // [26:11] line_number, [31:27] zero
	output logic [UserW-1:0]  m_tuser,    // [3:0] token_kind, [4] char_valid
	output logic              m_tlast     // token_end
);

	// lexer state
	mode_t             mode_q;
	logic              cf_q;
	logic              esc_q;
	logic [CountW-1:0] tc_q;
	logic [LineW-1:0]  lc_q;
	logic [CountW-1:0] limit_q;

	// two-entry output buffer
	result_t           slot0_q;
	result_t           slot1_q;
	logic [1:0]        cnt_q;

	// next state and results
	mode_t             n_mode;
	logic              n_cf;
	logic              n_esc;
	logic [CountW-1:0] n_tc;
	logic [LineW-1:0]  n_lc;
	logic [1:0]        nres;
	result_t           r0;
	result_t           r1;

	// byte classification
	logic [CharW-1:0]  b;
	logic              eoi;
	logic              is_nl;
	logic              is_sp;
	logic              is_bad;
	logic              cmt_skip;
	logic [CharW-1:0]  cc;
	logic [LineW-1:0]  lc_nx;
	logic [CountW-1:0] tc_inc;
	logic [CountW-1:0] lim;
	logic              too_long;

	// start-of-token decode
	logic              st_n;
	result_t           st_res;
	mode_t             st_mode;
	logic [CountW-1:0] st_tc;
	logic              st_esc;
	logic [KindW-1:0]  punct_kind;
	logic              is_punct;

	logic              take;
	logic              pop;

	function automatic result_t mk(input logic [KindW-1:0] kind, input logic [CharW-1:0] ch,
		input logic valid, input logic last, input logic [ErrW-1:0] err,
		input logic [LineW-1:0] line);
		result_t r;
		r.token_kind  = kind;
		r.text_char   = ch;
		r.char_valid  = valid;
		r.token_end   = last;
		r.error_code  = err;
		r.line_number = line;
		return r;
	endfunction

	assign b          = s_tdata;
	assign eoi        = s_tuser;
	assign is_nl      = (b == CH_NL);
	assign is_sp      = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
	assign is_bad     = !is_sp && (b < CH_SPACE || b > CH_TILDE);
	assign cmt_skip   = !is_nl && (cf_q || b == CH_HASH);
	assign cc         = is_sp ? CH_SPACE : b;
	assign lc_nx      = (!eoi && is_nl && lc_q != LINE_MAX) ? lc_q + 1'b1 : lc_q;
	assign tc_inc     = tc_q + 1'b1;
	assign lim        = (limit_q < LIMIT_MIN) ? LIMIT_MIN : limit_q;
	assign too_long   = (tc_inc >= lim);

	always_comb begin
		is_punct   = 1'b1;
		punct_kind = KIND_ASSIGN;
		unique case (b)
			CH_EQ:     punct_kind = KIND_ASSIGN;
			CH_SEMI:   punct_kind = KIND_SEMI;
			CH_LBRACE: punct_kind = KIND_LBRACE;
			CH_RBRACE: punct_kind = KIND_RBRACE;
			CH_LBRACK: punct_kind = KIND_LBRACKET;
			CH_RBRACK: punct_kind = KIND_RBRACKET;
			CH_COMMA:  punct_kind = KIND_COMMA;
			default:   is_punct   = 1'b0;
		endcase
	end

	// token start from idle or after an identifier; the first identifier char never hits the limit (>= 4)
	always_comb begin
		st_n    = 1'b0;
		st_res  = mk(KIND_IDENT, '0, 1'b0, 1'b0, ERR_NONE, lc_nx);
		st_mode = MODE_IDLE;
		st_tc   = tc_q;
		st_esc  = esc_q;
		priority if (is_sp) begin
			st_mode = MODE_IDLE;
		end else if (is_bad) begin
			st_n    = 1'b1;
			st_res  = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_NONPRINT, lc_nx);
			st_mode = MODE_ERR;
		end else if (is_punct) begin
			st_n    = 1'b1;
			st_res  = mk(punct_kind, b, 1'b1, 1'b1, ERR_NONE, lc_nx);
		end else if (b == CH_QUOTE) begin
			st_mode = MODE_STRING;
			st_tc   = '0;
			st_esc  = 1'b0;
		end else if (b == CH_LPAREN) begin
			st_mode = MODE_CAST;
			st_tc   = '0;
			st_esc  = 1'b0;
		end else if (is_ident_char(b)) begin
			st_n    = 1'b1;
			st_res  = mk(KIND_IDENT, b, 1'b1, 1'b0, ERR_NONE, lc_nx);
			st_mode = MODE_IDENT;
			st_tc   = {{(CountW-1){1'b0}}, 1'b1};
			st_esc  = 1'b0;
		end else begin
			st_n    = 1'b1;
			st_res  = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_UNEXP, lc_nx);
			st_mode = MODE_ERR;
		end
	end

	always_comb begin
		n_mode = mode_q;
		n_cf   = cf_q;
		n_esc  = esc_q;
		n_tc   = tc_q;
		n_lc   = lc_q;
		nres   = 2'd0;
		r0     = mk(KIND_IDENT, '0, 1'b0, 1'b0, ERR_NONE, lc_nx);
		r1     = r0;
		if (mode_q != MODE_ERR) begin
			if (eoi) begin
				if (mode_q == MODE_STRING || mode_q == MODE_CAST) begin
					r0     = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_EOF_OPEN, lc_nx);
					nres   = 2'd1;
					n_mode = MODE_ERR;
				end else if (mode_q == MODE_IDENT) begin
					r0     = mk(KIND_IDENT, '0, 1'b0, 1'b1, ERR_NONE, lc_nx);
					r1     = mk(KIND_EOF, '0, 1'b0, 1'b1, ERR_NONE, lc_nx);
					nres   = 2'd2;
					n_mode = MODE_IDLE;
				end else begin
					r0     = mk(KIND_EOF, '0, 1'b0, 1'b1, ERR_NONE, lc_nx);
					nres   = 2'd1;
					n_mode = MODE_IDLE;
				end
			end else begin
				n_lc = lc_nx;
				if (is_nl) begin
					n_cf = 1'b0;
				end else if (b == CH_HASH) begin
					n_cf = 1'b1;
				end
				if (!cmt_skip) begin
					unique case (mode_q)
						MODE_IDENT: begin
							if (!is_sp && !is_bad && is_ident_char(b)) begin
								nres = 2'd1;
								n_tc = tc_inc;
								if (too_long) begin
									r0     = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_TOO_LONG, lc_nx);
									n_mode = MODE_ERR;
								end else begin
									r0 = mk(KIND_IDENT, b, 1'b1, 1'b0, ERR_NONE, lc_nx);
								end
							end else begin
								// identifier end marker, then the byte starts a new token
								r0     = mk(KIND_IDENT, '0, 1'b0, 1'b1, ERR_NONE, lc_nx);
								r1     = st_res;
								nres   = st_n ? 2'd2 : 2'd1;
								n_mode = st_mode;
								n_tc   = st_tc;
								n_esc  = st_esc;
							end
						end
						MODE_STRING: begin
							nres = 2'd1;
							if (is_bad) begin
								r0     = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_NONPRINT, lc_nx);
								n_mode = MODE_ERR;
							end else if (cc == CH_QUOTE && !esc_q) begin
								r0     = mk(KIND_STRING, '0, 1'b0, 1'b1, ERR_NONE, lc_nx);
								n_mode = MODE_IDLE;
								n_esc  = 1'b0;
							end else begin
								n_esc = (cc == CH_BSLASH);
								n_tc  = tc_inc;
								if (too_long) begin
									r0     = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_TOO_LONG, lc_nx);
									n_mode = MODE_ERR;
								end else begin
									r0 = mk(KIND_STRING, cc, 1'b1, 1'b0, ERR_NONE, lc_nx);
								end
							end
						end
						MODE_CAST: begin
							nres = 2'd1;
							if (is_bad) begin
								r0     = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_NONPRINT, lc_nx);
								n_mode = MODE_ERR;
							end else if (cc == CH_RPAREN) begin
								r0     = mk(KIND_CAST, '0, 1'b0, 1'b1, ERR_NONE, lc_nx);
								n_mode = MODE_IDLE;
							end else begin
								n_tc = tc_inc;
								if (too_long) begin
									r0     = mk(KIND_ERROR, '0, 1'b0, 1'b1, ERR_TOO_LONG, lc_nx);
									n_mode = MODE_ERR;
								end else begin
									r0 = mk(KIND_CAST, cc, 1'b1, 1'b0, ERR_NONE, lc_nx);
								end
							end
						end
						MODE_IDLE: begin
							r0     = st_res;
							nres   = {1'b0, st_n};
							n_mode = st_mode;
							n_tc   = st_tc;
							n_esc  = st_esc;
						end
						default: begin
							n_mode = mode_q;
						end
					endcase
				end
			end
		end
	end

	// accept while the buffer drains to empty this cycle
	assign s_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_tready);
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			cf_q    <= 1'b0;
			esc_q   <= 1'b0;
			tc_q    <= '0;
			lc_q    <= '0;
			limit_q <= LIMIT_RESET;
			cnt_q   <= 2'd0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (take) begin
				mode_q <= n_mode;
				cf_q   <= n_cf;
				esc_q  <= n_esc;
				tc_q   <= n_tc;
				lc_q   <= n_lc;
				cnt_q  <= nres;
			end else if (pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign m_tdata = {{(DataW-CharW-ErrW-LineW){1'b0}}, slot0_q.line_number,
		slot0_q.error_code, slot0_q.text_char};
	assign m_tuser = {slot0_q.char_valid, slot0_q.token_kind};
	assign m_tlast = slot0_q.token_end;

endmodule

// ===== src/ctl_checker.sv =====
module ctl_checker
	import ctl_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DataW-1:0]  m_tdata,
	input logic [UserW-1:0]  m_tuser,
	input logic              m_tlast
);

	logic [KindW-1:0] kind;
	logic [ErrW-1:0]  err;

	assign kind = m_tuser[KindW-1:0];
	assign err  = m_tdata[CharW+ErrW-1:CharW];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output changed while stalled");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind == KIND_ERROR |-> m_tlast && !m_tuser[KindW] && err != ERR_NONE)
		else $error("malformed error transaction");

	a_no_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && kind != KIND_ERROR |-> err == ERR_NONE)
		else $error("error code on a non-error transaction");

	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[KindW] |-> kind != KIND_EOF && kind != KIND_ERROR)
		else $error("character on eof or error transaction");

endmodule

bind config_text_lexer ctl_checker u_ctl_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
